// File: hdl/rbp_pkg.sv
// Shared types and constants for the restart budget policy unit.
// No dependencies; imported by the top level and its checker.
package rbp_pkg;

    typedef enum logic [2:0] {
        ACT_RESTART     = 3'd0,
        ACT_STOP_BUDGET = 3'd1,
        ACT_STOP_RANGE  = 3'd2,
        ACT_STOP_ENTRY  = 3'd3,
        ACT_IGNORED     = 3'd4
    } action_t;

    typedef enum logic [7:0] {
        CFG_DRIVER_ENTRY  = 8'd0,
        CFG_BEAM_ENTRY    = 8'd1,
        CFG_DRIVER_BUDGET = 8'd2,
        CFG_BEAM_BUDGET   = 8'd3
    } cfg_index_t;

    localparam logic        CMD_FAULT  = 1'b0;
    localparam logic        CMD_DEBUG  = 1'b1;

    localparam logic [7:0]  CHILD_BLK     = 8'd2;
    localparam logic [7:0]  CHILD_BEAM    = 8'd5;
    localparam logic [7:0]  GONE_CH_BLK   = 8'd10;
    localparam logic [7:0]  DEBUG_CH_LAST = 8'd3;

    localparam logic [63:0] DRIVER_ENTRY_RST  = 64'h0000_0000_0020_0000;
    localparam logic [63:0] BEAM_ENTRY_RST    = 64'd0;
    localparam logic [7:0]  DRIVER_BUDGET_RST = 8'd8;
    localparam logic [7:0]  BEAM_BUDGET_RST   = 8'd64;

endpackage

// File: hdl/restart_budget_policy_unit.sv
// Restart budget policy unit: per-child restart counters kept in a
// synchronous count table with a registered read. Uses rbp_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready, command, ident): one beat is a fault
//   from a child or a debug request on a channel. Output channel
//   (out_valid/out_ready) carries one result beat per input beat.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   the entry and budget registers; it is always ready.
// Pipeline: an accepted beat reads the count table into the lookup stage
//   (the read is registered on accept), and the decision then loads the
//   output register as the beat leaves the lookup stage.
// Throughput: one beat per cycle while out_ready is high. The table read is
//   issued on accept and the updated count is written back as the decision
//   completes; a write to the entry read in the same cycle is forwarded.
// Stall: while out_ready is low the output register holds its result; the
//   lookup stage holds one more beat, after which in_ready drops.
// Reset: all per-entry valid bits clear, so every count reads as zero;
//   registers return to their reset values. No clearing pass is needed, the
//   block accepts beats from the first cycle after reset.
module restart_budget_policy_unit #(
    parameter int MAX_CHILDREN = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [7:0]  ident,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  action,
    output logic [7:0]  target_child,
    output logic [63:0] resume_address,
    output logic        notify_valid,
    output logic [7:0]  notify_channel,
    output logic [7:0]  new_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import rbp_pkg::*;

    localparam int IDX_W = $clog2(MAX_CHILDREN);
    localparam logic [8:0] NUM_CHILD = 9'(MAX_CHILDREN);

    // configuration registers
    logic [63:0] driver_entry_reg;
    logic [63:0] beam_entry_reg;
    logic [7:0]  driver_budget_reg;
    logic [7:0]  beam_budget_reg;

    // count table and its valid bits
    logic [7:0]  cnt_mem [MAX_CHILDREN];
    logic        vld_reg [MAX_CHILDREN];
    logic [7:0]  rd_data_reg;
    logic        rd_vld_reg;

    // lookup stage
    logic        a_valid_reg, a_valid_next;
    logic        a_cmd_reg;
    logic [7:0]  a_ident_reg;
    logic        fwd_reg;
    logic [7:0]  fwd_data_reg;

    // output register
    logic        out_valid_reg, out_valid_next;
    action_t     action_reg;
    logic [7:0]  target_reg;
    logic [63:0] resume_reg;
    logic        notify_reg;
    logic [7:0]  count_reg;

    logic        in_fire;
    logic        a_fire;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] a_idx;

    logic        ignored;
    logic        in_range;
    logic        is_beam;
    logic [7:0]  budget;
    logic [63:0] entry;
    logic [7:0]  cur_count;
    logic        do_restart;
    action_t     act_c;
    logic [7:0]  target_c;
    logic [63:0] resume_c;
    logic        notify_c;
    logic [7:0]  count_c;

    assign cfg_ready = 1'b1;
    assign a_fire    = a_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !a_valid_reg || a_fire;
    assign in_fire   = in_valid && in_ready;
    assign rd_idx    = ident[IDX_W-1:0];
    assign a_idx     = a_ident_reg[IDX_W-1:0];

    // decision on the looked-up count
    always_comb
    begin
        ignored   = (a_cmd_reg == CMD_DEBUG) && (a_ident_reg > DEBUG_CH_LAST);
        in_range  = ({1'b0, a_ident_reg} < NUM_CHILD);
        is_beam   = (a_ident_reg == CHILD_BEAM);
        budget    = is_beam ? beam_budget_reg : driver_budget_reg;
        entry     = is_beam ? beam_entry_reg : driver_entry_reg;
        cur_count = fwd_reg ? fwd_data_reg : (rd_vld_reg ? rd_data_reg : 8'd0);
        do_restart = 1'b0;
        target_c  = a_ident_reg;
        resume_c  = 64'd0;
        count_c   = cur_count;
        priority if (ignored)
        begin
            act_c    = ACT_IGNORED;
            target_c = 8'd0;
            count_c  = 8'd0;
        end
        else if (!in_range)
        begin
            act_c   = ACT_STOP_RANGE;
            count_c = 8'd0;
        end
        else if (cur_count >= budget)
        begin
            act_c = ACT_STOP_BUDGET;
        end
        else if (entry == 64'd0)
        begin
            act_c = ACT_STOP_ENTRY;
        end
        else
        begin
            act_c      = ACT_RESTART;
            resume_c   = entry;
            count_c    = cur_count + 8'd1;
            do_restart = 1'b1;
        end
        notify_c = (act_c == ACT_STOP_BUDGET || act_c == ACT_STOP_ENTRY)
                   && (a_ident_reg == CHILD_BLK);
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (a_fire)
        begin
            a_valid_next = 1'b0;
        end
        if (in_fire)
        begin
            a_valid_next = 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (a_fire)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                // same entry written this cycle: the read returns stale data
                fwd_reg <= a_fire && do_restart && (a_idx == rd_idx);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            driver_entry_reg  <= DRIVER_ENTRY_RST;
            beam_entry_reg    <= BEAM_ENTRY_RST;
            driver_budget_reg <= DRIVER_BUDGET_RST;
            beam_budget_reg   <= BEAM_BUDGET_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DRIVER_ENTRY:  driver_entry_reg  <= cfg_data;
                CFG_BEAM_ENTRY:    beam_entry_reg    <= cfg_data;
                CFG_DRIVER_BUDGET: driver_budget_reg <= cfg_data[7:0];
                CFG_BEAM_BUDGET:   beam_budget_reg   <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHILDREN; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (a_fire && do_restart)
        begin
            vld_reg[a_idx] <= 1'b1;
        end
    end

    // count table: write back on restart, read on accept
    always_ff @(posedge clk)
    begin
        if (a_fire && do_restart)
        begin
            cnt_mem[a_idx] <= count_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rd_data_reg <= cnt_mem[rd_idx];
            rd_vld_reg  <= vld_reg[rd_idx];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_cmd_reg   <= command;
            a_ident_reg <= ident;
            if (a_fire)
            begin
                fwd_data_reg <= count_c;
            end
        end
        if (a_fire)
        begin
            action_reg <= act_c;
            target_reg <= target_c;
            resume_reg <= resume_c;
            notify_reg <= notify_c;
            count_reg  <= count_c;
        end
    end

    assign out_valid      = out_valid_reg;
    assign action         = action_reg;
    assign target_child   = target_reg;
    assign resume_address = resume_reg;
    assign notify_valid   = notify_reg;
    assign notify_channel = notify_reg ? GONE_CH_BLK : 8'd0;
    assign new_count      = count_reg;

endmodule

// File: hdl/rbp_checker.sv
// Port-level checker for restart_budget_policy_unit, attached by bind.
// Uses rbp_pkg for action codes and fixed channel and child ids.
module rbp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  action,
    input logic [7:0]  target_child,
    input logic [63:0] resume_address,
    input logic        notify_valid,
    input logic [7:0]  notify_channel,
    input logic [7:0]  new_count
);
    import rbp_pkg::*;

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(action)
        && $stable(target_child) && $stable(new_count))
        else $error("result beat changed while stalled");

    a_notify_blk: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && notify_valid |-> notify_channel == GONE_CH_BLK
        && target_child == CHILD_BLK
        && (action == ACT_STOP_BUDGET || action == ACT_STOP_ENTRY))
        else $error("notification on wrong child or action");

    a_restart_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == ACT_RESTART |-> resume_address != 64'd0
        && new_count != 8'd0 && !notify_valid)
        else $error("restart without entry or count");

    a_stop_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action != ACT_RESTART |-> resume_address == 64'd0)
        else $error("stop carries a resume address");

    a_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == ACT_IGNORED |-> target_child == 8'd0
        && new_count == 8'd0 && !notify_valid)
        else $error("ignored beat carries payload");

endmodule

bind restart_budget_policy_unit rbp_checker u_rbp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .action         (action),
    .target_child   (target_child),
    .resume_address (resume_address),
    .notify_valid   (notify_valid),
    .notify_channel (notify_channel),
    .new_count      (new_count)
);

// File: tb/sv/restart_budget_policy_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for restart_budget_policy_unit: valid/ready driver and monitor
// around a cycle-free predictor of the per-child restart budget. Depends on rbp_pkg.
module restart_budget_policy_unit_tb;
    import rbp_pkg::*;

    localparam int CHILD_SLOTS = 64;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int NUM_PHASES = 8;

    typedef struct packed {
        logic       cmd;
        logic [7:0] id;
    } fault_beat_t;

    typedef struct packed {
        action_t     act;
        logic [7:0]  child;
        logic [63:0] resume;
        logic        notify;
        logic [7:0]  gone_ch;
        logic [7:0]  count;
    } policy_verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        command = 1'b0;
    logic [7:0]  ident = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  action;
    logic [7:0]  target_child;
    logic [63:0] resume_address;
    logic        notify_valid;
    logic [7:0]  notify_channel;
    logic [7:0]  new_count;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = 8'd0;
    logic [63:0] cfg_data = 64'd0;

    // predicted register file and count table
    logic [63:0] pol_driver_entry;
    logic [63:0] pol_beam_entry;
    logic [7:0]  pol_driver_budget;
    logic [7:0]  pol_beam_budget;
    logic [7:0]  restart_tally [CHILD_SLOTS];

    fault_beat_t     fault_backlog [$];
    policy_verdict_t pending_verdicts [$];
    fault_beat_t     next_beat;
    policy_verdict_t got_verdict;
    int              mismatches = 0;
    int              send_gap = 0;
    int              stall_gap = 0;
    bit              quiet_tail = 1'b0;

    restart_budget_policy_unit #(.MAX_CHILDREN(CHILD_SLOTS)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .ident          (ident),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .action         (action),
        .target_child   (target_child),
        .resume_address (resume_address),
        .notify_valid   (notify_valid),
        .notify_channel (notify_channel),
        .new_count      (new_count),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic policy_verdict_t decide_restart(logic cmd, logic [7:0] id);
        policy_verdict_t v;
        logic [7:0]      budget;
        logic [63:0]     entry;
        v = '0;
        v.act = ACT_RESTART;
        if (cmd == CMD_DEBUG && id > DEBUG_CH_LAST)
        begin
            v.act = ACT_IGNORED;
            return v;
        end
        v.child = id;
        if (id >= CHILD_SLOTS)
        begin
            v.act = ACT_STOP_RANGE;
            return v;
        end
        budget = (id == CHILD_BEAM) ? pol_beam_budget : pol_driver_budget;
        entry = (id == CHILD_BEAM) ? pol_beam_entry : pol_driver_entry;
        v.count = restart_tally[id];
        if (restart_tally[id] >= budget)
            v.act = ACT_STOP_BUDGET;
        else if (entry == 64'd0)
            v.act = ACT_STOP_ENTRY;
        else
        begin
            restart_tally[id] = restart_tally[id] + 8'd1;
            v.count = restart_tally[id];
            v.resume = entry;
        end
        if (v.act != ACT_RESTART && id == CHILD_BLK)
        begin
            v.notify = 1'b1;
            v.gone_ch = GONE_CH_BLK;
        end
        return v;
    endfunction

    // input driver: predict on each accepted beat, then present the next one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                pending_verdicts.push_back(decide_restart(command, ident));
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap = send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (fault_backlog.size() != 0)
                begin
                    next_beat = fault_backlog.pop_front();
                    in_valid <= 1'b1;
                    command <= next_beat.cmd;
                    ident <= next_beat.id;
                    if (!quiet_tail && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 12);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // result monitor with random backpressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual action %0d child %0d",
                             $time, action, target_child);
                    mismatches++;
                end
                else
                begin
                    got_verdict = pending_verdicts.pop_front();
                    check_field("action", got_verdict.act, action);
                    check_field("target_child", got_verdict.child, target_child);
                    check_field("resume_address", got_verdict.resume, resume_address);
                    check_field("notify_valid", got_verdict.notify, notify_valid);
                    check_field("notify_channel", got_verdict.gone_ch, notify_channel);
                    check_field("new_count", got_verdict.count, new_count);
                end
            end
            if (stall_gap != 0)
            begin
                stall_gap = stall_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 7) == 0)
                    stall_gap = $urandom_range(1, 12);
            end
        end
    end

    task automatic queue_beat(logic cmd, logic [7:0] id);
        fault_backlog.push_back('{cmd: cmd, id: id});
    endtask

    // hold until every queued beat is accepted and every result has come back
    task automatic drain();
        do
            @(posedge clk);
        while (fault_backlog.size() != 0 || in_valid || pending_verdicts.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // call at a rising edge; returns at the edge that takes the write
    task automatic write_reg(cfg_index_t idx, logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_DRIVER_ENTRY:  pol_driver_entry = data;
            CFG_BEAM_ENTRY:    pol_beam_entry = data;
            CFG_DRIVER_BUDGET: pol_driver_budget = data[7:0];
            CFG_BEAM_BUDGET:   pol_beam_budget = data[7:0];
            default: ;
        endcase
    endtask

    function automatic logic [63:0] pick_entry();
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return 64'd1;
            2: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [7:0] pick_budget();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            2, 3: return 8'($urandom_range(1, 12));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin : sequencer
        int          sent;
        int          roll;
        logic        cmd;
        logic [7:0]  id;
        logic [63:0] d_entry;
        logic [63:0] b_entry;
        logic [7:0]  d_budget;
        logic [7:0]  b_budget;

        pol_driver_entry = DRIVER_ENTRY_RST;
        pol_beam_entry = BEAM_ENTRY_RST;
        pol_driver_budget = DRIVER_BUDGET_RST;
        pol_beam_budget = BEAM_BUDGET_RST;
        foreach (restart_tally[i])
            restart_tally[i] = 8'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: beam child has no entry yet
        queue_beat(CMD_FAULT, 8'd0);
        queue_beat(CMD_FAULT, CHILD_BLK);
        queue_beat(CMD_FAULT, CHILD_BEAM);
        queue_beat(CMD_FAULT, 8'd63);
        queue_beat(CMD_FAULT, 8'd64);
        queue_beat(CMD_FAULT, 8'd255);
        queue_beat(CMD_FAULT, 8'd128);
        for (int ch = 0; ch <= 3; ch++)
            queue_beat(CMD_DEBUG, ch[7:0]);
        queue_beat(CMD_DEBUG, 8'd4);
        queue_beat(CMD_DEBUG, 8'd255);
        drain();

        // budget dropped below live counts
        write_reg(CFG_DRIVER_BUDGET, 64'd0);
        write_reg(CFG_BEAM_ENTRY, '1);
        cfg_valid <= 1'b0;
        queue_beat(CMD_FAULT, 8'd0);
        queue_beat(CMD_FAULT, CHILD_BLK);
        queue_beat(CMD_FAULT, CHILD_BEAM);
        queue_beat(CMD_DEBUG, CHILD_BLK);
        drain();

        write_reg(CFG_DRIVER_BUDGET, 64'd255);
        write_reg(CFG_DRIVER_ENTRY, 64'd0);
        cfg_valid <= 1'b0;
        queue_beat(CMD_FAULT, CHILD_BLK);
        queue_beat(CMD_FAULT, 8'd1);
        drain();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    d_entry = {$urandom, $urandom} | 64'd1;
                    b_entry = {$urandom, $urandom} | 64'd1;
                    d_budget = DRIVER_BUDGET_RST;
                    b_budget = BEAM_BUDGET_RST;
                end
                1:
                begin
                    d_entry = '1;
                    b_entry = '1;
                    d_budget = 8'd255;
                    b_budget = 8'd255;
                end
                2:
                begin
                    d_entry = 64'd1;
                    b_entry = 64'd0;
                    d_budget = 8'd0;
                    b_budget = 8'd0;
                end
                default:
                begin
                    d_entry = pick_entry();
                    b_entry = pick_entry();
                    d_budget = pick_budget();
                    b_budget = pick_budget();
                end
            endcase
            write_reg(CFG_DRIVER_ENTRY, d_entry);
            write_reg(CFG_BEAM_ENTRY, b_entry);
            write_reg(CFG_DRIVER_BUDGET, {56'd0, d_budget});
            write_reg(CFG_BEAM_BUDGET, {56'd0, b_budget});
            cfg_valid <= 1'b0;
            if (phase == NUM_PHASES - 1)
                quiet_tail = 1'b1;

            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                roll = $urandom_range(0, 99);
                // weight faults toward the first few children so budgets run out
                if (roll < 55)
                begin
                    cmd = CMD_FAULT;
                    id = 8'($urandom_range(0, 7));
                end
                else if (roll < 70)
                begin
                    cmd = CMD_FAULT;
                    id = 8'($urandom_range(0, CHILD_SLOTS - 1));
                end
                else if (roll < 85)
                begin
                    cmd = CMD_DEBUG;
                    id = 8'($urandom_range(0, 3));
                end
                else if (roll < 93)
                begin
                    cmd = CMD_DEBUG;
                    id = 8'($urandom_range(0, 255));
                end
                else
                begin
                    cmd = CMD_FAULT;
                    id = 8'($urandom_range(0, 255));
                end
                queue_beat(cmd, id);
                sent++;
            end
            drain();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("PASS restart_budget_policy_unit");
        else
            $display("FAIL restart_budget_policy_unit");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("FAIL restart_budget_policy_unit");
        $finish;
    end

endmodule

// File: files.f
hdl/rbp_pkg.sv
hdl/restart_budget_policy_unit.sv
hdl/rbp_checker.sv
tb/sv/restart_budget_policy_unit_tb.sv
